// ----- sv/mlfs_pkg.sv -----
// Package for the marker/length frame scanner: types, sizes and helpers.
package mlfs_pkg;

    localparam int MAX_MARKER   = 8;
    localparam int LENGTH_BYTES = 3;
    localparam int FILL_W       = 4;
    localparam int SEL_W        = 3;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;

    localparam logic [1:0] CFG_MARKER_LEN   = 2'd0;
    localparam logic [1:0] CFG_MARKER_BYTES = 2'd1;
    localparam logic [1:0] CFG_MAX_PRODUCTS = 2'd2;

    typedef struct packed {
        logic [23:0] frame_length;
        logic [15:0] product_count;
        logic        is_summary;
        logic        last_result;
    } t_result;

    typedef struct packed {
        logic    valid0;
        logic    valid1;
        t_result res0;
        t_result res1;
    } t_push;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctl;

    // Marker length in use: 0 counts as 1, above MAX_MARKER is clamped.
    function automatic logic [FILL_W-1:0] active_len(input logic [3:0] len);
        logic [FILL_W-1:0] m;
        m = len;
        if (m == '0) begin
            m = FILL_W'(1);
        end else if (m > FILL_W'(MAX_MARKER)) begin
            m = FILL_W'(MAX_MARKER);
        end
        return m;
    endfunction

endpackage

// ----- sv/mlfs_win_cell.sv -----
// One byte cell of the sliding match window.
module mlfs_win_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlfs_pkg::t_win_ctl i_ctl,
    input  logic [7:0]        i_din,
    input  logic [7:0]        i_marker,
    output logic [7:0]        o_byte,
    output logic              o_hit
);
    import mlfs_pkg::*;

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.clear) begin
            n_byte = '0;
        end else if (i_ctl.shift) begin
            n_byte = i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    // compare the byte this cell takes on a shift
    assign o_hit  = (i_din == i_marker);
    assign o_byte = r_byte;

endmodule

// ----- sv/mlfs_ctrl.sv -----
// Scan control: mode, length field, skip counter, message count, results.
module mlfs_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last_byte,
    input  logic [mlfs_pkg::FILL_W-1:0] i_mlen,
    input  logic [15:0]                 i_max_products,
    input  logic                        i_win_hit,
    output mlfs_pkg::t_win_ctl          o_win_ctl,
    output mlfs_pkg::t_push             o_push
);
    import mlfs_pkg::*;

    localparam logic [1:0] MODE_HUNT   = 2'd0;
    localparam logic [1:0] MODE_LENGTH = 2'd1;
    localparam logic [1:0] MODE_SKIP   = 2'd2;

    logic [1:0]        r_mode,  n_mode;
    logic [FILL_W-1:0] r_fill,  n_fill;
    logic [23:0]       r_acc,   n_acc;
    logic [1:0]        r_seen,  n_seen;
    logic [23:0]       r_skip,  n_skip;
    logic [15:0]       r_count, n_count;

    logic              active;
    logic              frame;
    logic [23:0]       acc_next;
    logic [23:0]       hdr;
    logic [23:0]       skip_calc;
    logic [23:0]       skip_dec;
    logic [FILL_W-1:0] fill_inc;
    t_result           frame_res;
    t_result           summ_res;

    always_comb begin
        n_mode    = r_mode;
        n_fill    = r_fill;
        n_acc     = r_acc;
        n_seen    = r_seen;
        n_skip    = r_skip;
        n_count   = r_count;
        o_win_ctl = '0;
        frame     = 1'b0;
        active    = (r_count < i_max_products);
        acc_next  = {r_acc[15:0], i_data_byte};
        hdr       = 24'(i_mlen) + 24'(LENGTH_BYTES);
        skip_calc = (acc_next > hdr) ? (acc_next - hdr) : '0;
        skip_dec  = (r_skip != '0) ? (r_skip - 24'd1) : r_skip;
        fill_inc  = (r_fill < FILL_W'(MAX_MARKER)) ? (r_fill + FILL_W'(1)) : r_fill;

        if (i_accept && active) begin
            unique case (r_mode)
                MODE_LENGTH: begin
                    n_acc  = acc_next;
                    n_seen = r_seen + 2'd1;
                    if (r_seen == 2'(LENGTH_BYTES - 1)) begin
                        n_count         = r_count + 16'd1;
                        frame           = 1'b1;
                        n_skip          = skip_calc;
                        n_seen          = '0;
                        n_fill          = '0;
                        o_win_ctl.clear = 1'b1;
                        n_mode          = (skip_calc != '0) ? MODE_SKIP : MODE_HUNT;
                    end
                end
                MODE_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_mode = MODE_HUNT;
                    end
                end
                default: begin
                    o_win_ctl.shift = 1'b1;
                    n_fill          = fill_inc;
                    n_mode          = MODE_HUNT;
                    if ((fill_inc >= i_mlen) && i_win_hit) begin
                        n_mode = MODE_LENGTH;
                        n_acc  = '0;
                        n_seen = '0;
                    end
                end
            endcase
        end

        frame_res.frame_length  = acc_next;
        frame_res.product_count = n_count;
        frame_res.is_summary    = 1'b0;
        frame_res.last_result   = !i_last_byte;

        summ_res.frame_length  = '0;
        summ_res.product_count = n_count;
        summ_res.is_summary    = 1'b1;
        summ_res.last_result   = 1'b1;

        o_push        = '0;
        o_push.res0   = frame ? frame_res : summ_res;
        o_push.res1   = summ_res;
        o_push.valid0 = frame || (i_accept && i_last_byte);
        o_push.valid1 = frame && i_last_byte;

        // end of stream clears the scan state and the message count; configuration stays
        if (i_accept && i_last_byte) begin
            n_mode          = MODE_HUNT;
            n_fill          = '0;
            n_acc           = '0;
            n_seen          = '0;
            n_skip          = '0;
            n_count         = '0;
            o_win_ctl.clear = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HUNT;
            r_fill  <= '0;
            r_acc   <= '0;
            r_seen  <= '0;
            r_skip  <= '0;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_fill  <= n_fill;
            r_acc   <= n_acc;
            r_seen  <= n_seen;
            r_skip  <= n_skip;
            r_count <= n_count;
        end
    end

endmodule

// ----- sv/mlfs_out_queue.sv -----
// Small result queue: takes up to two results a cycle, hands out one.
module mlfs_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlfs_pkg::t_push   i_push,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output mlfs_pkg::t_result o_res
);
    import mlfs_pkg::*;

    t_result             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic [QPTR_W-1:0]   wr1;
    logic                pop;
    logic [1:0]          npush;

    assign pop     = (r_cnt != '0) && i_ready;
    assign npush   = 2'(i_push.valid0) + 2'(i_push.valid1);
    assign wr1     = r_wr + QPTR_W'(1);
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];
    // room for a request that brings two results
    assign o_space = (r_cnt <= QCNT_W'(QDEPTH - 2));

    always_comb begin
        n_wr  = r_wr + QPTR_W'(npush);
        n_rd  = pop ? (r_rd + QPTR_W'(1)) : r_rd;
        n_cnt = r_cnt + QCNT_W'(npush) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.valid1) begin
            r_mem[wr1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- sv/marker_length_frame_scanner_core.sv -----
// Top level of the marker/length frame scanner.
//
// Takes one stream byte per cycle. A row of eight byte cells forms the
// sliding window; each cell compares the byte it is about to take with its
// marker byte, so a match is known in the cycle the last marker byte is
// accepted. The next three bytes give the big-endian message length and the
// rest of the message is skipped. Each byte yields zero, one or two results
// (message, then end-of-stream summary on the last byte); results go into a
// four-entry queue, and o_ready drops while fewer than two entries are free.
// With the output side ready, the rate is one byte per cycle; results leave
// one per cycle while i_ready is high. Configuration is to be written via
// i_cfg_we/i_cfg_index/i_cfg_data while the block is idle; it is not enforced.
module marker_length_frame_scanner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_frame_length,
    output logic [15:0] o_product_count,
    output logic        o_is_summary,
    output logic        o_last_result
);
    import mlfs_pkg::*;

    logic [3:0]        r_marker_len;
    logic [63:0]       r_marker_bytes;
    logic [15:0]       r_max_products;

    logic [FILL_W-1:0] mlen;
    logic              accept;
    t_win_ctl          win_ctl;
    t_push             push;
    t_result           res;
    logic [7:0]        cell_byte [MAX_MARKER];
    logic [MAX_MARKER-1:0] cell_hit;
    logic [MAX_MARKER-1:0] cell_use;
    logic              win_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker_len   <= 4'd4;
            r_marker_bytes <= '0;
            r_max_products <= 16'hFFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MARKER_LEN:   r_marker_len   <= i_cfg_data[3:0];
                CFG_MARKER_BYTES: r_marker_bytes <= i_cfg_data;
                CFG_MAX_PRODUCTS: r_max_products <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign mlen   = active_len(r_marker_len);
    assign accept = i_valid && o_ready;

    // cell p holds the p-th newest byte and matches marker byte m-1-p
    for (genvar p = 0; p < MAX_MARKER; p++) begin : g_cell
        logic [FILL_W-1:0] idx;
        logic [7:0]        din;
        logic [7:0]        mbyte;

        assign idx         = mlen - FILL_W'(1) - FILL_W'(p);
        assign mbyte       = r_marker_bytes[{idx[SEL_W-1:0], 3'b000} +: 8];
        assign cell_use[p] = (FILL_W'(p) < mlen);

        if (p == 0) begin : g_head
            assign din = i_data_byte;
        end else begin : g_body
            assign din = cell_byte[p-1];
        end

        mlfs_win_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (win_ctl),
            .i_din    (din),
            .i_marker (mbyte),
            .o_byte   (cell_byte[p]),
            .o_hit    (cell_hit[p])
        );
    end

    assign win_hit = &(cell_hit | ~cell_use);

    mlfs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_mlen         (mlen),
        .i_max_products (r_max_products),
        .i_win_hit      (win_hit),
        .o_win_ctl      (win_ctl),
        .o_push         (push)
    );

    mlfs_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    assign o_frame_length  = res.frame_length;
    assign o_product_count = res.product_count;
    assign o_is_summary    = res.is_summary;
    assign o_last_result   = res.last_result;

endmodule

// ----- sv/mlfs_checker.sv -----
// Port-level checks for the frame scanner, bound to the top level.
module mlfs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [23:0] o_frame_length,
    input logic [15:0] o_product_count,
    input logic        o_is_summary,
    input logic        o_last_result
);

    // a stalled result stays valid and holds its length, count and summary flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_frame_length)
            && $stable(o_product_count) && $stable(o_is_summary))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_summary |-> o_last_result && (o_frame_length == 24'd0))
        else $error("summary not final or has a length");

    a_frame_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_summary |-> (o_product_count != 16'd0))
        else $error("message result with zero count");

    // a message result that is not final is followed by its summary
    a_frame_then_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_is_summary && !o_last_result
            |=> o_valid && o_is_summary)
        else $error("summary missing after message result");

endmodule

bind marker_length_frame_scanner_core mlfs_checker u_mlfs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_frame_length  (o_frame_length),
    .o_product_count (o_product_count),
    .o_is_summary    (o_is_summary),
    .o_last_result   (o_last_result)
);
